>>> hdl/clcag_pkg.sv
// Shared types, widths and helpers for the color sensor lux / CCT / auto-gain block.
package clcag_pkg;

    localparam int DVD_W = 48;
    localparam int DVS_W = 26;
    localparam int CNT_W = 6;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [5:0] gain_factor(input logic [1:0] code);
        logic [5:0] f;
        case (code)
            2'd0:    f = 6'd1;
            2'd1:    f = 6'd4;
            2'd2:    f = 6'd16;
            default: f = 6'd60;
        endcase
        return f;
    endfunction

    function automatic logic [15:0] sat16(input logic [DVD_W-1:0] v);
        logic [15:0] r;
        if (v > 48'd65535)
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/clcag_div.sv
// Restoring bit-serial divider shared by all seven division jobs of the block.
module clcag_div (
    input  logic              clk,
    input  logic              rst_n,
    input  clcag_pkg::div_req_t req,
    output clcag_pkg::div_rsp_t rsp
);
    import clcag_pkg::*;

    logic [DVD_W-1:0] sh_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             qbit;

    assign trial = {rem_reg, sh_reg[DVD_W-1]};
    assign qbit  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sh_reg  <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (qbit)
            begin
                rem_reg <= DVS_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[DVS_W-1:0];
            end
            sh_reg <= {sh_reg[DVD_W-2:0], qbit};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = sh_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hdl/color_sensor_lux_cct_autogain.sv
// Top level: color sensor sample processor with lux, color temperature and auto exposure.
// One sample is accepted when the block is idle; it then passes the PREP and MUL setup
// states, then seven divisions (clear percentage for short integration, red, green and
// blue percentages, lux, color temperature and the retune time) run one after another
// through a single bit-serial divider, each with an issue state and a wait state, then
// the DONE state forms the result and the block returns to idle for the next sample. The
// result sits in an output register, so the next sample can be accepted while it waits
// to be taken; a sample whose result is ready while the previous one is still waiting
// holds until that one is taken. Lux and color temperature use the integration and gain
// in effect before the sample; the settings after any retune are reported with it.
module color_sensor_lux_cct_autogain (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // clear_raw[15:0], red_raw[31:16], green_raw[47:32], blue_raw[63:48]
    input  logic [63:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // clear_pct[15:0], red_pct[31:16], green_pct[47:32], blue_pct[63:48], lux[84:64],
    // lux_ok[85], kelvin[99:86], kelvin_ok[100], publish[101], next_atime[109:102],
    // next_gain[111:110], retuned[112], zero fill[119:113]
    output logic [119:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import clcag_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [2:0] JOB_CLEAR = 3'd0;
    localparam logic [2:0] JOB_RED   = 3'd1;
    localparam logic [2:0] JOB_GREEN = 3'd2;
    localparam logic [2:0] JOB_BLUE  = 3'd3;
    localparam logic [2:0] JOB_LUX   = 3'd4;
    localparam logic [2:0] JOB_KEL   = 3'd5;
    localparam logic [2:0] JOB_TUNE  = 3'd6;

    localparam logic [1:0] REG_AUTO  = 2'd0;
    localparam logic [1:0] REG_ATIME = 2'd1;
    localparam logic [1:0] REG_GAIN  = 2'd2;
    localparam logic [1:0] REG_GLASS = 2'd3;

    logic [2:0]  state_reg;
    logic [2:0]  job_reg;
    logic        auto_reg;
    logic [7:0]  start_atime_reg;
    logic [1:0]  start_gain_reg;
    logic [15:0] ga_reg;
    logic [7:0]  atime_reg;
    logic [1:0]  gain_reg;

    logic [15:0] c_reg, r_reg, g_reg, b_reg;
    logic [8:0]  n_reg;
    logic [5:0]  gf_reg;
    logic [26:0] s_reg;
    logic [42:0] prod_reg;
    logic [25:0] den_reg;
    logic [25:0] rnum_reg;
    logic [17:0] rden_reg;
    logic        up_reg, dn_reg;

    logic [15:0] cp_reg, rp_reg, gp_reg, bp_reg;
    logic [47:0] luxq_reg;
    logic        luxr_reg;
    logic [13:0] kelq_reg;
    logic [47:0] tuneq_reg;
    logic        tuner_reg;

    logic         m_tvalid_reg;
    logic [119:0] m_tdata_reg;

    div_req_t req;
    div_rsp_t rsp;

    clcag_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [26:0] pos, neg;
    assign pos = 27'(r_reg) * 27'd136 + 27'(g_reg) * 27'd1000;
    assign neg = 27'(b_reg) * 27'd444;

    logic up_c, dn_c;
    assign up_c = (gain_reg != 2'd3) && (c_reg < 16'd13107) && (n_reg >= 9'd251);
    assign dn_c = (gain_reg != 2'd0) && (c_reg >= 16'd45875) && (n_reg <= 9'd83);

    logic [15:0] cc;
    assign cc = (c_reg == 16'd0) ? 16'd1 : c_reg;

    // clear * 25600 / 65535 with 65535 = 2^16 - 1
    logic [31:0] cx;
    logic [16:0] cy;
    logic [15:0] cfull;
    assign cx    = 32'(c_reg) * 32'd25600;
    assign cy    = 17'(cx[31:16]) + 17'(cx[15:0]);
    assign cfull = cx[31:16] + 16'(cy >= 17'd65535);

    always_comb
    begin
        req.start    = (state_reg == ST_ISSUE);
        req.dividend = '0;
        req.divisor  = '0;
        case (job_reg)
            JOB_CLEAR:
            begin
                req.dividend = 48'(c_reg) * 48'd25;
                req.divisor  = 26'(n_reg);
            end
            JOB_RED:
            begin
                req.dividend = 48'(r_reg) * 48'd25600;
                req.divisor  = 26'(c_reg);
            end
            JOB_GREEN:
            begin
                req.dividend = 48'(g_reg) * 48'd25600;
                req.divisor  = 26'(c_reg);
            end
            JOB_BLUE:
            begin
                req.dividend = 48'(b_reg) * 48'd25600;
                req.divisor  = 26'(c_reg);
            end
            JOB_LUX:
            begin
                req.dividend = 48'(prod_reg) * 48'd31;
                req.divisor  = den_reg;
            end
            JOB_KEL:
            begin
                req.dividend = 48'(b_reg) * 48'd3810;
                req.divisor  = 26'(r_reg);
            end
            JOB_TUNE:
            begin
                req.dividend = 48'(rnum_reg);
                req.divisor  = 26'(rden_reg);
            end
            default:
            begin
                req.dividend = '0;
                req.divisor  = '0;
            end
        endcase
    end

    logic [16:0]  level;
    logic         c_ok;
    logic         lux_over;
    logic         kel_big;
    logic [20:0]  lux_v;
    logic         lux_ok_v;
    logic [13:0]  kel_v;
    logic         kel_ok_v;
    logic         pub_v;
    logic [7:0]   na_v;
    logic [1:0]   ng_v;
    logic [7:0]   atime_n;
    logic [1:0]   gain_n;
    logic         ret_v;
    logic [8:0]   ceil_q;

    always_comb
    begin
        if (n_reg >= 9'd64)
        begin
            level = 17'd65535;
        end
        else if (n_reg == 9'd63)
        begin
            level = 17'd64512;
        end
        else
        begin
            level = 17'(n_reg) * 17'd768;
        end
        c_ok     = (c_reg != 16'd0) && (17'(c_reg) < level);
        lux_over = (luxq_reg > 48'd1600000) || ((luxq_reg == 48'd1600000) && luxr_reg);
        kel_big  = (32'(b_reg) * 32'd3810) > (32'(r_reg) * 32'd13609);
        lux_v    = 21'd0;
        lux_ok_v = 1'b0;
        kel_v    = 14'd0;
        kel_ok_v = 1'b0;
        if (c_ok)
        begin
            if (lux_over)
            begin
                lux_v = 21'd1600000;
            end
            else
            begin
                lux_v    = luxq_reg[20:0];
                lux_ok_v = 1'b1;
                if (r_reg != 16'd0)
                begin
                    if (kel_big)
                    begin
                        kel_v = 14'd15000;
                    end
                    else
                    begin
                        kel_v    = kelq_reg + 14'd1391;
                        kel_ok_v = 1'b1;
                    end
                end
            end
        end
        pub_v = !auto_reg || (c_reg < 16'd65530) || ((gain_reg == 2'd0) && (n_reg <= 9'd83));

        ceil_q = 9'(tuneq_reg) + 9'(tuner_reg);
        if (32'(rnum_reg) > (32'(rden_reg) << 8))
        begin
            na_v = 8'd0;
        end
        else if ((32'(rnum_reg) * 32'd12) < (32'(rden_reg) * 32'd770))
        begin
            na_v = 8'd191;
        end
        else
        begin
            na_v = 8'(9'd256 - ceil_q);
        end
        if (up_reg)
        begin
            ng_v = gain_reg + 2'd1;
        end
        else if (dn_reg)
        begin
            ng_v = gain_reg - 2'd1;
        end
        else
        begin
            ng_v = gain_reg;
        end
        ret_v   = auto_reg && ((na_v != atime_reg) || (ng_v != gain_reg));
        atime_n = ret_v ? na_v : atime_reg;
        gain_n  = ret_v ? ng_v : gain_reg;
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            job_reg         <= JOB_CLEAR;
            auto_reg        <= 1'b0;
            start_atime_reg <= 8'd192;
            start_gain_reg  <= 2'd0;
            ga_reg          <= 16'd256;
            atime_reg       <= 8'd192;
            gain_reg        <= 2'd0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AUTO:
                    begin
                        auto_reg  <= cfg_data[0];
                        atime_reg <= cfg_data[0] ? 8'd192 : start_atime_reg;
                        gain_reg  <= start_gain_reg;
                    end
                    REG_ATIME:
                    begin
                        start_atime_reg <= cfg_data[7:0];
                        atime_reg       <= auto_reg ? 8'd192 : cfg_data[7:0];
                        gain_reg        <= start_gain_reg;
                    end
                    REG_GAIN:
                    begin
                        start_gain_reg <= cfg_data[1:0];
                        atime_reg      <= auto_reg ? 8'd192 : start_atime_reg;
                        gain_reg       <= cfg_data[1:0];
                    end
                    REG_GLASS:
                    begin
                        ga_reg <= cfg_data;
                    end
                    default:
                    begin
                        ga_reg <= ga_reg;
                    end
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    job_reg   <= JOB_CLEAR;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (rsp.done)
                    begin
                        if (job_reg == JOB_TUNE)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            job_reg   <= job_reg + 3'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        atime_reg    <= atime_n;
                        gain_reg     <= gain_n;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            c_reg  <= s_tdata[15:0];
            r_reg  <= s_tdata[31:16];
            g_reg  <= s_tdata[47:32];
            b_reg  <= s_tdata[63:48];
            n_reg  <= 9'd256 - 9'(atime_reg);
            gf_reg <= gain_factor(gain_reg);
        end
        if (state_reg == ST_PREP)
        begin
            s_reg    <= (pos > neg) ? pos - neg : 27'd0;
            den_reg  <= 26'(15'(n_reg) * 15'(gf_reg)) * 26'd3840;
            up_reg   <= up_c;
            dn_reg   <= dn_c;
            rnum_reg <= dn_c ? (26'(n_reg) * 26'd39321) << 2 : 26'(n_reg) * 26'd39321;
            rden_reg <= up_c ? 18'(cc) << 2 : 18'(cc);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 43'(s_reg) * 43'(ga_reg);
        end
        if (state_reg == ST_WAIT && rsp.done)
        begin
            case (job_reg)
                JOB_CLEAR: cp_reg <= (c_reg == 16'd0) ? 16'd0 :
                                     (n_reg <= 9'd64) ? sat16(rsp.quotient) : cfull;
                JOB_RED:   rp_reg <= (c_reg == 16'd0) ? 16'd0 : sat16(rsp.quotient);
                JOB_GREEN: gp_reg <= (c_reg == 16'd0) ? 16'd0 : sat16(rsp.quotient);
                JOB_BLUE:  bp_reg <= (c_reg == 16'd0) ? 16'd0 : sat16(rsp.quotient);
                JOB_LUX:
                begin
                    luxq_reg <= rsp.quotient;
                    luxr_reg <= rsp.remainder != '0;
                end
                JOB_KEL:   kelq_reg <= rsp.quotient[13:0];
                JOB_TUNE:
                begin
                    tuneq_reg <= rsp.quotient;
                    tuner_reg <= rsp.remainder != '0;
                end
                default:   kelq_reg <= kelq_reg;
            endcase
        end
        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= {7'd0, ret_v, gain_n, atime_n, pub_v, kel_ok_v, kel_v,
                            lux_ok_v, lux_v, bp_reg, gp_reg, rp_reg, cp_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> bench/tb_color_sensor_lux_cct_autogain.sv
// Testbench for the color sensor lux / CCT / auto-gain block: directed and random samples.
`timescale 1ns / 1ps

typedef struct packed {
    logic [15:0] clear_raw;
    logic [15:0] red_raw;
    logic [15:0] green_raw;
    logic [15:0] blue_raw;
} sample_t;

typedef struct packed {
    logic [15:0] clear_pct;
    logic [15:0] red_pct;
    logic [15:0] green_pct;
    logic [15:0] blue_pct;
    logic [20:0] lux;
    logic        lux_ok;
    logic [13:0] kelvin;
    logic        kelvin_ok;
    logic        publish;
    logic [7:0]  next_atime;
    logic [1:0]  next_gain;
    logic        retuned;
} reading_t;

localparam logic [1:0] REG_AUTO_MODE   = 2'd0;
localparam logic [1:0] REG_START_ATIME = 2'd1;
localparam logic [1:0] REG_START_GAIN  = 2'd2;
localparam logic [1:0] REG_GLASS_ATTEN = 2'd3;

class reading_scoreboard;
    logic        auto_mode;
    logic [7:0]  start_atime;
    logic [1:0]  start_gain;
    logic [15:0] glass_atten;
    logic [7:0]  atime_now;
    logic [1:0]  gain_now;
    reading_t    pending[$];
    int          mismatches;
    int          checked;

    function new();
        auto_mode = 1'b0;
        start_atime = 8'd192;
        start_gain = 2'd0;
        glass_atten = 16'd256;
        mismatches = 0;
        checked = 0;
        reload();
    endfunction

    function void reload();
        atime_now = auto_mode ? 8'd192 : start_atime;
        gain_now = start_gain;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            REG_AUTO_MODE:   begin auto_mode = val[0]; reload(); end
            REG_START_ATIME: begin start_atime = val[7:0]; reload(); end
            REG_START_GAIN:  begin start_gain = val[1:0]; reload(); end
            default:         glass_atten = val;
        endcase
    endfunction

    function longint unsigned clip16(longint unsigned v);
        return v > 65535 ? 65535 : v;
    endfunction

    function void note_sample(sample_t s);
        longint unsigned c, r, g, b, n, gf, level, pos, neg, sum, num, den;
        logic [1:0] ng;
        logic [7:0] na;
        reading_t e;
        c = s.clear_raw;
        r = s.red_raw;
        g = s.green_raw;
        b = s.blue_raw;
        n = 256 - atime_now;
        case (gain_now)
            2'd0: gf = 1;
            2'd1: gf = 4;
            2'd2: gf = 16;
            default: gf = 60;
        endcase
        e = '0;
        if (c != 0)
        begin
            e.clear_pct = 16'((n <= 64) ? clip16(c * 25 / n) : clip16(c * 25600 / 65535));
            e.red_pct = 16'(clip16(r * 25600 / c));
            e.green_pct = 16'(clip16(g * 25600 / c));
            e.blue_pct = 16'(clip16(b * 25600 / c));
        end
        level = (n >= 64) ? 65535 : (n == 63 ? 1024 * n : 768 * n);
        if (c != 0 && c < level)
        begin
            pos = 136 * r + 1000 * g;
            neg = 444 * b;
            sum = pos > neg ? pos - neg : 0;
            num = sum * glass_atten * 31;
            den = 3840 * n * gf;
            if (num > 1600000 * den)
            begin
                e.lux = 21'd1600000;
            end
            else
            begin
                e.lux = 21'(num / den);
                e.lux_ok = 1'b1;
                if (r != 0)
                begin
                    if (3810 * b > 13609 * r)
                    begin
                        e.kelvin = 14'd15000;
                    end
                    else
                    begin
                        e.kelvin = 14'(3810 * b / r + 1391);
                        e.kelvin_ok = 1'b1;
                    end
                end
            end
        end
        e.publish = !auto_mode || c < 65530 || (gain_now == 0 && n <= 83);
        if (auto_mode)
        begin
            num = 39321 * n;
            den = (c == 0) ? 1 : c;
            ng = gain_now;
            if (gain_now < 3 && c < 13107 && n >= 251)
            begin
                ng = gain_now + 2'd1;
                den = den * 4;
            end
            if (gain_now > 0 && c >= 45875 && n <= 83)
            begin
                ng = gain_now - 2'd1;
                num = num * 4;
            end
            if (num > 256 * den)
                na = 8'd0;
            else if (12 * num < 770 * den)
                na = 8'd191;
            else
                na = 8'(256 - (num + den - 1) / den);
            if (na != atime_now || ng != gain_now)
            begin
                atime_now = na;
                gain_now = ng;
                e.retuned = 1'b1;
            end
        end
        e.next_atime = atime_now;
        e.next_gain = gain_now;
        pending.push_back(e);
    endfunction

    function void check_reading(logic [119:0] d);
        reading_t a, e;
        a.clear_pct = d[15:0];
        a.red_pct = d[31:16];
        a.green_pct = d[47:32];
        a.blue_pct = d[63:48];
        a.lux = d[84:64];
        a.lux_ok = d[85];
        a.kelvin = d[99:86];
        a.kelvin_ok = d[100];
        a.publish = d[101];
        a.next_atime = d[109:102];
        a.next_gain = d[111:110];
        a.retuned = d[112];
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected reading %h", d);
            return;
        end
        e = pending.pop_front();
        if (a !== e || d[119:113] !== 7'd0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("reading %0d: expected %p, got %p", checked, e, a);
        end
    endfunction
endclass

module tb_color_sensor_lux_cct_autogain;
    import clcag_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    reading_scoreboard sb;
    bit  quiet;
    int  idle_cycles;
    int  sent;
    bit  timed_out;

    color_sensor_lux_cct_autogain uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side: random stall bursts, check every accepted item
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_reading(m_tdata);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk)
                    if (rst_n && m_tvalid && m_tready)
                        sb.check_reading(m_tdata);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: cycles without any item accepted
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_sample(sample_t s);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s.blue_raw, s.green_raw, s.red_raw, s.clear_raw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(s);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            3: return 16'($urandom_range(13000, 13200));
            4: return 16'($urandom_range(45800, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t rnd_sample();
        sample_t s;
        s.clear_raw = rnd16();
        s.red_raw = rnd16();
        s.green_raw = rnd16();
        s.blue_raw = rnd16();
        if ($urandom_range(0, 2) != 0 && s.clear_raw != 0)
        begin
            // plausible scene: channels at or below clear
            s.red_raw = 16'($urandom_range(0, s.clear_raw));
            s.green_raw = 16'($urandom_range(0, s.clear_raw));
            s.blue_raw = 16'($urandom_range(0, s.clear_raw));
        end
        return s;
    endfunction

    initial
    begin
        sample_t s;
        int phase;
        sb = new();
        quiet = 0;
        sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_AUTO_MODE;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at reset settings
        send_sample('{16'd0, 16'd100, 16'd100, 16'd100});
        send_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_sample('{16'd1000, 16'd0, 16'd500, 16'd200});
        send_sample('{16'd1000, 16'd10, 16'd500, 16'd2000});
        send_sample('{16'd1000, 16'd100, 16'd0, 16'hFFFF});
        send_sample('{16'd65534, 16'd65535, 16'd65535, 16'd0});
        send_sample('{16'd1, 16'hFFFF, 16'hFFFF, 16'h0});
        drain();
        write_reg(REG_GLASS_ATTEN, 16'hFFFF);
        write_reg(REG_START_GAIN, 16'd0);
        write_reg(REG_START_ATIME, 16'd255);
        send_sample('{16'd30000, 16'd65535, 16'd65535, 16'd0});
        send_sample('{16'd800, 16'd300, 16'd300, 16'd300});
        drain();
        write_reg(REG_GLASS_ATTEN, 16'd0);
        write_reg(REG_START_ATIME, 16'd193);
        send_sample('{16'd48000, 16'd100, 16'd100, 16'd100});
        send_sample('{16'd49000, 16'd100, 16'd100, 16'd100});
        drain();
        write_reg(REG_START_ATIME, 16'd194);
        write_reg(REG_GLASS_ATTEN, 16'd1);
        send_sample('{16'd47615, 16'd10000, 16'd100, 16'd100});
        drain();
        write_reg(REG_START_ATIME, 16'd0);
        write_reg(REG_START_GAIN, 16'd3);
        write_reg(REG_GLASS_ATTEN, 16'd256);
        write_reg(REG_AUTO_MODE, 16'd1);
        send_sample('{16'd100, 16'd50, 16'd30, 16'd20});
        send_sample('{16'd65535, 16'd50, 16'd30, 16'd20});
        send_sample('{16'd0, 16'd0, 16'd0, 16'd0});
        send_sample('{16'd5, 16'd1, 16'd1, 16'd1});
        send_sample('{16'd60000, 16'd1, 16'd1, 16'd1});
        drain();

        for (phase = 0; phase < 8; phase++)
        begin
            if (phase == 7)
                quiet = 1;
            write_reg(REG_GLASS_ATTEN, phase == 0 ? 16'd1 : ($urandom_range(0, 1) ?
                      16'd256 : 16'($urandom_range(1, 65535))));
            write_reg(REG_START_ATIME, phase == 1 ? 16'd255 : phase == 2 ? 16'd0 :
                      16'($urandom_range(0, 255)));
            write_reg(REG_START_GAIN, 16'($urandom_range(0, 3)));
            write_reg(REG_AUTO_MODE, 16'(phase % 2));
            repeat (100)
            begin
                s = rnd_sample();
                send_sample(s);
            end
            drain();
        end

        $display("%0d samples checked over manual and auto exposure, gain and glass settings",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d readings missing", sb.mismatches,
                     sb.pending.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/clcag_pkg.sv
hdl/clcag_div.sv
hdl/color_sensor_lux_cct_autogain.sv
bench/tb_color_sensor_lux_cct_autogain.sv
